@@ design/spiral_pixel_layout_generator_defines.svh @@
// assertion macros for the spiral pixel layout generator
// expects clk and rst_n in the scope of the including module
`ifndef SPIRAL_PIXEL_LAYOUT_GENERATOR_DEFINES_SVH
`define SPIRAL_PIXEL_LAYOUT_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SPL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spl assertion failed");

// next-cycle implication, disabled in reset
`define SPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spl assertion failed");

`endif

@@ design/spl_pkg.sv @@
// shared constants, types and register indexes of the spiral pixel layout generator
// no dependencies
package spl_pkg;

    // image and record sizes
    localparam int MAX_SIDE   = 1024;
    localparam int POS_W      = $clog2(MAX_SIDE);
    localparam int MAX_REPEAT = 64;
    localparam int REP_W      = 7;
    localparam int VAL_W      = 16;
    localparam int LEG_W      = 11;
    localparam int CNT_W      = 21;
    localparam int TURN_W     = 3;

    localparam logic [LEG_W-1:0]  LEG_MAX   = 11'd2047;
    localparam logic [TURN_W-1:0] TURNS_MAX = 3'd4;

    // layout codes
    localparam logic [1:0] MODE_SPIRAL = 2'd0;
    localparam logic [1:0] MODE_HSERP  = 2'd1;
    localparam logic [1:0] MODE_VSERP  = 2'd2;

    // walk directions
    localparam logic [1:0] DIR_0 = 2'd0;
    localparam logic [1:0] DIR_1 = 2'd1;
    localparam logic [1:0] DIR_2 = 2'd2;
    localparam logic [1:0] DIR_3 = 2'd3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LAST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LAST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLING_OFF = 3'd5;

    // register reset values
    localparam logic [1:0]       MODE_RST      = MODE_SPIRAL;
    localparam logic [POS_W-1:0] SIDE_RST      = 10'd255;
    localparam logic [POS_W-1:0] HEIGHT_RST    = 10'd255;
    localparam logic [VAL_W-1:0] SAMPLE_LO_RST = 16'h0000;
    localparam logic [VAL_W-1:0] SAMPLE_HI_RST = 16'hFFFF;

    // walk state after reset: spiral centred on the reset image
    localparam logic [POS_W-1:0] POS_RST = SIDE_RST >> 1;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [1:0] layout_mode;
        pos_t       side_last;
        pos_t       height_last;
    } cfg_t;

    typedef struct packed {
        logic restart;
        logic turn;
        logic draw;
    } walk_cmd_t;

    typedef struct packed {
        pos_t pos_x;
        pos_t pos_y;
        logic steps_zero;
    } walk_stat_t;

endpackage

@@ design/spl_if.sv @@
// record and pixel channel interfaces: valid/ready with payload
// depends on spl_pkg
interface spl_record_if;
    logic                       valid;
    logic                       ready;
    logic                       first_record;
    logic [spl_pkg::VAL_W-1:0]  record_value;
    logic [spl_pkg::VAL_W-1:0]  sample_key;
    logic [spl_pkg::REP_W-1:0]  repeat_count;

    modport source (output valid, first_record, record_value, sample_key, repeat_count,
                    input ready);
    modport sink   (input valid, first_record, record_value, sample_key, repeat_count,
                    output ready);
endinterface

interface spl_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [spl_pkg::POS_W-1:0]  pixel_x;
    logic [spl_pkg::POS_W-1:0]  pixel_y;
    logic [spl_pkg::VAL_W-1:0]  pixel_value;
    logic                       last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_value, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_value, last_pixel,
                    output ready);
endinterface

@@ design/spl_walk.sv @@
// walk unit: position, direction and leg state with the shared step/turn logic
// depends on spl_pkg
module spl_walk
(
    input  logic                clk,
    input  logic                rst_n,
    input  spl_pkg::cfg_t       cfg,
    input  spl_pkg::walk_cmd_t  cmd,
    output spl_pkg::walk_stat_t stat
);

    spl_pkg::pos_t                pos_x_reg, pos_x_next;
    spl_pkg::pos_t                pos_y_reg, pos_y_next;
    logic [1:0]                   dir_reg, dir_next;
    logic [spl_pkg::LEG_W-1:0]    leg_reg, leg_next;
    logic [spl_pkg::LEG_W-1:0]    steps_reg, steps_next;
    logic                         second_reg, second_next;

    logic [1:0]                   mode;
    logic [spl_pkg::LEG_W-1:0]    serp_len;
    logic [1:0]                   t_dir;
    logic [spl_pkg::LEG_W-1:0]    t_leg;
    logic [spl_pkg::LEG_W-1:0]    steps_dec;
    spl_pkg::pos_t                dx;
    spl_pkg::pos_t                dy;

    // effective layout: unused code walks as spiral
    always_comb
    begin
        if (cfg.layout_mode == spl_pkg::MODE_HSERP || cfg.layout_mode == spl_pkg::MODE_VSERP)
            mode = cfg.layout_mode;
        else
            mode = spl_pkg::MODE_SPIRAL;
        serp_len = (mode == spl_pkg::MODE_HSERP) ? spl_pkg::LEG_W'(cfg.side_last)
                                                 : spl_pkg::LEG_W'(cfg.height_last);
    end

    // turn unit: next direction and leg length
    always_comb
    begin
        t_dir = dir_reg + 2'd1;
        if (mode != spl_pkg::MODE_SPIRAL)
            t_leg = (leg_reg == spl_pkg::LEG_W'(1)) ? serp_len : spl_pkg::LEG_W'(1);
        else if (second_reg && leg_reg < spl_pkg::LEG_MAX)
            t_leg = leg_reg + spl_pkg::LEG_W'(1);
        else
            t_leg = leg_reg;
        steps_dec = (steps_reg == '0) ? '0 : steps_reg - spl_pkg::LEG_W'(1);
    end

    // step unit: one-pixel move per layout and direction, wrapping at the position width (1024), not at the image edge
    always_comb
    begin
        dx = '0;
        dy = '0;
        unique case (mode)
            spl_pkg::MODE_VSERP:
            begin
                unique case (dir_reg)
                    spl_pkg::DIR_0: dx = spl_pkg::POS_W'(1);
                    spl_pkg::DIR_1: dy = spl_pkg::POS_W'(1);
                    spl_pkg::DIR_2: dx = spl_pkg::POS_W'(1);
                    default:        dy = '1;
                endcase
            end
            spl_pkg::MODE_HSERP:
            begin
                unique case (dir_reg)
                    spl_pkg::DIR_0: dy = spl_pkg::POS_W'(1);
                    spl_pkg::DIR_1: dx = spl_pkg::POS_W'(1);
                    spl_pkg::DIR_2: dy = spl_pkg::POS_W'(1);
                    default:        dx = '1;
                endcase
            end
            default:
            begin
                unique case (dir_reg)
                    spl_pkg::DIR_0: dy = '1;
                    spl_pkg::DIR_1: dx = spl_pkg::POS_W'(1);
                    spl_pkg::DIR_2: dy = spl_pkg::POS_W'(1);
                    default:        dx = '1;
                endcase
            end
        endcase
    end

    // next walk state
    always_comb
    begin
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        dir_next    = dir_reg;
        leg_next    = leg_reg;
        steps_next  = steps_reg;
        second_next = second_reg;
        priority if (cmd.restart)
        begin
            dir_next    = spl_pkg::DIR_1;
            second_next = 1'b0;
            if (mode == spl_pkg::MODE_SPIRAL)
            begin
                pos_x_next = cfg.side_last >> 1;
                pos_y_next = cfg.side_last >> 1;
                leg_next   = spl_pkg::LEG_W'(1);
                steps_next = spl_pkg::LEG_W'(1);
            end
            else
            begin
                pos_x_next = '0;
                pos_y_next = '0;
                leg_next   = serp_len;
                steps_next = serp_len;
            end
        end
        else if (cmd.turn)
        begin
            dir_next    = t_dir;
            leg_next    = t_leg;
            steps_next  = t_leg;
            second_next = ~second_reg;
        end
        else if (cmd.draw)
        begin
            pos_x_next = pos_x_reg + dx;
            pos_y_next = pos_y_reg + dy;
            if (steps_dec == '0)
            begin
                dir_next    = t_dir;
                leg_next    = t_leg;
                steps_next  = t_leg;
                second_next = ~second_reg;
            end
            else
            begin
                steps_next = steps_dec;
            end
        end
        else
        begin
            // no command: walk state holds
        end
    end

    // walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= spl_pkg::POS_RST;
            pos_y_reg  <= spl_pkg::POS_RST;
            dir_reg    <= spl_pkg::DIR_1;
            leg_reg    <= spl_pkg::LEG_W'(1);
            steps_reg  <= spl_pkg::LEG_W'(1);
            second_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            dir_reg    <= dir_next;
            leg_reg    <= leg_next;
            steps_reg  <= steps_next;
            second_reg <= second_next;
        end
    end

    assign stat.pos_x      = pos_x_reg;
    assign stat.pos_y      = pos_y_reg;
    assign stat.steps_zero = (steps_reg == '0);

endmodule

@@ design/spiral_pixel_layout_generator.sv @@
// operation: a record is taken in the idle state; a setup state follows, then the walk
//   puts one pixel per cycle into the output register while that register is free,
//   with a leg turn wherever a leg has no steps left (at most four in a row before a
//   pixel); a skipped record returns from setup to idle; no new record until idle again
// reset: rst_n clears registers to their reset values and centres the spiral walk
// top level: record sequencer, configuration registers, output register; uses spl_walk
`include "spiral_pixel_layout_generator_defines.svh"
module spiral_pixel_layout_generator
(
    input  logic                               clk,
    input  logic                               rst_n,
    spl_record_if.sink                         record_ch,
    spl_pixel_if.source                        pixel_ch,
    input  logic                               cfg_we,
    input  logic [spl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_SETUP, S_WALK} state_t;

    state_t                        state_reg, state_next;

    // configuration registers
    logic [1:0]                    mode_reg;
    spl_pkg::pos_t                 side_reg;
    spl_pkg::pos_t                 height_reg;
    logic [spl_pkg::VAL_W-1:0]     sample_lo_reg;
    logic [spl_pkg::VAL_W-1:0]     sample_hi_reg;
    logic                          sampling_off_reg;

    // record and sequencer registers
    logic                          first_reg, first_next;
    logic [spl_pkg::VAL_W-1:0]     value_reg, value_next;
    logic [spl_pkg::VAL_W-1:0]     key_reg, key_next;
    logic [spl_pkg::REP_W-1:0]     reps_reg, reps_next;
    logic [spl_pkg::REP_W-1:0]     n_reg, n_next;
    logic [spl_pkg::CNT_W-1:0]     limit_reg, limit_next;
    logic [spl_pkg::CNT_W-1:0]     drawn_reg, drawn_next;
    logic [spl_pkg::TURN_W-1:0]    turns_reg, turns_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    spl_pkg::pos_t                 out_x_reg, out_x_next;
    spl_pkg::pos_t                 out_y_reg, out_y_next;
    logic [spl_pkg::VAL_W-1:0]     out_value_reg, out_value_next;
    logic                          out_last_reg, out_last_next;

    spl_pkg::cfg_t                 cfg;
    spl_pkg::walk_cmd_t            walk_cmd;
    spl_pkg::walk_stat_t           walk_stat;

    logic                          rec_xfer;
    logic                          out_free;
    logic                          skip;
    logic [spl_pkg::LEG_W-1:0]     side_p1;
    logic [2*spl_pkg::LEG_W-1:0]   area;
    logic [spl_pkg::REP_W-1:0]     reps_sat;
    logic [spl_pkg::REP_W-1:0]     n_inc;
    logic [spl_pkg::CNT_W-1:0]     drawn_inc;

    assign cfg.layout_mode = mode_reg;
    assign cfg.side_last   = side_reg;
    assign cfg.height_last = height_reg;

    spl_walk u_walk
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (walk_cmd),
        .stat  (walk_stat)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= spl_pkg::MODE_RST;
            side_reg         <= spl_pkg::SIDE_RST;
            height_reg       <= spl_pkg::HEIGHT_RST;
            sample_lo_reg    <= spl_pkg::SAMPLE_LO_RST;
            sample_hi_reg    <= spl_pkg::SAMPLE_HI_RST;
            sampling_off_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spl_pkg::REG_LAYOUT_MODE:  mode_reg         <= cfg_data[1:0];
                spl_pkg::REG_SIDE_LAST:    side_reg         <= cfg_data[spl_pkg::POS_W-1:0];
                spl_pkg::REG_HEIGHT_LAST:  height_reg       <= cfg_data[spl_pkg::POS_W-1:0];
                spl_pkg::REG_SAMPLE_LOW:   sample_lo_reg    <= cfg_data;
                spl_pkg::REG_SAMPLE_HIGH:  sample_hi_reg    <= cfg_data;
                spl_pkg::REG_SAMPLING_OFF: sampling_off_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshakes and helpers
    assign record_ch.ready = (state_reg == S_IDLE);
    assign rec_xfer        = record_ch.valid && record_ch.ready;
    assign out_free        = !out_valid_reg || pixel_ch.ready;

    assign pixel_ch.valid       = out_valid_reg;
    assign pixel_ch.pixel_x     = out_x_reg;
    assign pixel_ch.pixel_y     = out_y_reg;
    assign pixel_ch.pixel_value = out_value_reg;
    assign pixel_ch.last_pixel  = out_last_reg;

    // repeat count clamp, pixel limit and window test
    always_comb
    begin
        if (record_ch.repeat_count == '0)
            reps_sat = spl_pkg::REP_W'(1);
        else if (record_ch.repeat_count > spl_pkg::REP_W'(spl_pkg::MAX_REPEAT))
            reps_sat = spl_pkg::REP_W'(spl_pkg::MAX_REPEAT);
        else
            reps_sat = record_ch.repeat_count;
        side_p1   = spl_pkg::LEG_W'(side_reg) + spl_pkg::LEG_W'(1);
        area      = side_p1 * side_p1;
        skip      = !sampling_off_reg && (key_reg < sample_lo_reg || key_reg > sample_hi_reg);
        n_inc     = n_reg + spl_pkg::REP_W'(1);
        drawn_inc = drawn_reg + spl_pkg::CNT_W'(1);
    end

    // record sequencer
    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        value_next     = value_reg;
        key_next       = key_reg;
        reps_next      = reps_reg;
        n_next         = n_reg;
        limit_next     = limit_reg;
        drawn_next     = drawn_reg;
        turns_next     = turns_reg;
        out_valid_next = out_valid_reg && !pixel_ch.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        walk_cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (rec_xfer)
                begin
                    first_next = record_ch.first_record;
                    value_next = record_ch.record_value;
                    key_next   = record_ch.sample_key;
                    reps_next  = reps_sat;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                walk_cmd.restart = first_reg;
                if (first_reg)
                    drawn_next = '0;
                limit_next = spl_pkg::CNT_W'(area);
                n_next     = '0;
                turns_next = '0;
                state_next = skip ? S_IDLE : S_WALK;
            end
            S_WALK:
            begin
                priority if (n_reg == reps_reg || drawn_reg >= limit_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (walk_stat.steps_zero && turns_reg < spl_pkg::TURNS_MAX)
                begin
                    walk_cmd.turn = 1'b1;
                    turns_next    = turns_reg + spl_pkg::TURN_W'(1);
                end
                else if (out_free)
                begin
                    walk_cmd.draw  = 1'b1;
                    out_valid_next = 1'b1;
                    out_x_next     = walk_stat.pos_x;
                    out_y_next     = walk_stat.pos_y;
                    out_value_next = value_reg;
                    out_last_next  = (n_inc == reps_reg) || (drawn_inc == limit_reg);
                    n_next         = n_inc;
                    drawn_next     = drawn_inc;
                    turns_next     = '0;
                end
                else
                begin
                    // output register still full: wait
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b0;
            value_reg     <= '0;
            key_reg       <= '0;
            reps_reg      <= '0;
            n_reg         <= '0;
            limit_reg     <= '0;
            drawn_reg     <= '0;
            turns_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            value_reg     <= value_next;
            key_reg       <= key_next;
            reps_reg      <= reps_next;
            n_reg         <= n_next;
            limit_reg     <= limit_next;
            drawn_reg     <= drawn_next;
            turns_reg     <= turns_next;
            out_valid_reg <= out_valid_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_value_reg <= out_value_next;
            out_last_reg  <= out_last_next;
        end
    end

    // a pixel that is not the record's last leaves the walk busy
    `SPL_ASSERT_IMP(a_busy_mid_record, pixel_ch.valid && pixel_ch.ready && !pixel_ch.last_pixel, !record_ch.ready)
    // the pixel count of a record never passes its repeat count
    `SPL_ASSERT_IMP(a_count_bound, state_reg == S_WALK, n_reg <= reps_reg)
    // no more than four turns before a pixel
    `SPL_ASSERT_IMP(a_turn_bound, walk_cmd.turn, turns_reg < spl_pkg::TURNS_MAX)
    // a taken record always passes through setup
    `SPL_ASSERT_NEXT(a_setup_after_xfer, rec_xfer, state_reg == S_SETUP)

endmodule
